/* hw/rtl/tfd_pkg.sv */
// Shared types, codes and constants of the text framebuffer diff-flush block.
// No dependencies; every other file imports this package.
package tfd_pkg;

	// Field widths of the command and result items
	localparam int CMD_W  = 2;
	localparam int X_W    = 5;
	localparam int Y_W    = 4;
	localparam int CHAR_W = 8;
	localparam int KIND_W = 2;
	localparam int ROW_W  = 4;
	localparam int COL_W  = 5;

	// Configuration register widths and indexes
	localparam int WID_W     = 6;
	localparam int HGT_W     = 5;
	localparam int CFG_W     = 6;
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;
	localparam logic [WID_W-1:0] WIDTH_RST  = 6'd32;
	localparam logic [HGT_W-1:0] HEIGHT_RST = 5'd16;

	// Hard ceilings of the register fields
	localparam int COL_CAP = 32;
	localparam int ROW_CAP = 16;

	localparam int DEF_MAX_WIDTH  = 32;
	localparam int DEF_MAX_HEIGHT = 16;

	localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;

	// Command queue depth (power of two)
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_DRAW  = 2'd0,
		CMD_CLEAR = 2'd1,
		CMD_ERASE = 2'd2,
		CMD_FLUSH = 2'd3
	} tfd_cmd_e;

	typedef enum logic [KIND_W-1:0] {
		KIND_CELL = 2'd0,
		KIND_CLS  = 2'd1,
		KIND_HOME = 2'd2
	} tfd_kind_e;

	typedef enum logic [1:0] {
		OP_DRAW,
		OP_CLEAR,
		OP_ERASE,
		OP_FLUSH
	} tfd_op_e;

	typedef enum logic [2:0] {
		BS_INIT,
		BS_IDLE,
		BS_FILL,
		BS_HOME,
		BS_CLS,
		BS_SCAN,
		BS_END
	} tfd_bstate_e;

	// Classified operation handed from front to back
	typedef struct packed {
		tfd_op_e            code;
		logic [ROW_W-1:0]   row;
		logic [COL_W-1:0]   col;
		logic [CHAR_W-1:0]  ch;
		logic [WID_W-1:0]   ncols;
	} tfd_op_t;

	typedef struct packed {
		logic    push;
		tfd_op_t op;
	} tfd_push_t;

	typedef struct packed {
		logic    valid;
		tfd_op_t op;
	} tfd_head_t;

	function automatic int tfd_min(input int a, input int b);
		return (a < b) ? a : b;
	endfunction

	// Index width for n entries, at least one bit
	function automatic int tfd_bits(input int n);
		return (n <= 1) ? 1 : $clog2(n);
	endfunction

endpackage

/* hw/rtl/tfd_ifs.sv */
// Valid/ready channel interfaces for command items and result items.
// Depends on tfd_pkg for field widths.
interface tfd_req_if import tfd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  cmd;
	logic [X_W-1:0]    x;
	logic [Y_W-1:0]    y;
	logic [CHAR_W-1:0] ch;

	modport source (output valid, output cmd, output x, output y, output ch, input ready);
	modport sink (input valid, input cmd, input x, input y, input ch, output ready);
endinterface

interface tfd_rsp_if import tfd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [ROW_W-1:0]  row;
	logic [COL_W-1:0]  col;
	logic [CHAR_W-1:0] out_char;
	logic              last;

	modport source (output valid, output kind, output row, output col, output out_char,
		output last, input ready);
	modport sink (input valid, input kind, input row, input col, input out_char,
		input last, output ready);
endinterface

/* hw/rtl/tfd_front.sv */
// Front end: size registers, command intake and classification into queue ops.
// Depends on tfd_pkg and tfd_req_if.
module tfd_front import tfd_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	tfd_req_if.sink              req,
	input  logic                 q_full,
	input  logic                 init_done,
	output tfd_push_t            qpush
);

	localparam int COL_LIM = tfd_min(MAX_WIDTH, COL_CAP);
	localparam int ROW_LIM = tfd_min(MAX_HEIGHT, ROW_CAP);

	logic [WID_W-1:0] width_q;
	logic [HGT_W-1:0] height_q;
	logic [WID_W-1:0] w_eff;
	logic [HGT_W-1:0] h_eff;
	logic             in_range;
	logic             accept;

	// Size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_wdata[WID_W-1:0];
				REG_HEIGHT: height_q <= cfg_wdata[HGT_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective size: zero counts as one, clamp to the limit
	always_comb begin
		w_eff = width_q;
		if (width_q == '0)
			w_eff = WID_W'(1);
		else if (width_q > WID_W'(COL_LIM))
			w_eff = WID_W'(COL_LIM);
		h_eff = height_q;
		if (height_q == '0)
			h_eff = HGT_W'(1);
		else if (height_q > HGT_W'(ROW_LIM))
			h_eff = HGT_W'(ROW_LIM);
	end

	assign req.ready = !q_full && init_done;
	assign accept    = req.valid && req.ready;

	// Classify the item
	always_comb begin
		in_range     = ({1'b0, req.x} < w_eff) && ({1'b0, req.y} < h_eff);
		qpush.op.row = req.y;
		qpush.op.col = req.x;
		qpush.op.ch  = req.ch;
		qpush.op.ncols = '0;
		qpush.push   = accept;
		case (req.cmd)
			CMD_DRAW: begin
				qpush.op.code = OP_DRAW;
				qpush.op.row  = ROW_W'(h_eff - HGT_W'(1) - {1'b0, req.y});
				qpush.push    = accept && in_range;
			end
			CMD_CLEAR: qpush.op.code = OP_CLEAR;
			CMD_ERASE: qpush.op.code = OP_ERASE;
			CMD_FLUSH: begin
				qpush.op.code = OP_FLUSH;
				// a row outside the size scans no columns
				if ({1'b0, req.y} < h_eff)
					qpush.op.ncols = w_eff;
			end
			default: qpush.op.code = OP_DRAW;
		endcase
	end

endmodule

/* hw/rtl/tfd_queue.sv */
// Short op queue between front and back ends.
// Depends on tfd_pkg.
module tfd_queue import tfd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  tfd_push_t qpush,
	input  logic      pop,
	output logic      q_full,
	output tfd_head_t qhead
);

	localparam int PW = tfd_bits(QUEUE_DEPTH);

	tfd_op_t       slot_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   count_q;

	assign q_full      = (count_q == (PW+1)'(QUEUE_DEPTH));
	assign qhead.valid = (count_q != '0);
	assign qhead.op    = slot_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (qpush.push)
				wr_ptr_q <= wr_ptr_q + PW'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + PW'(1);
			if (qpush.push && !pop)
				count_q <= count_q + (PW+1)'(1);
			else if (pop && !qpush.push)
				count_q <= count_q - (PW+1)'(1);
		end
	end

	// Slot storage
	always_ff @(posedge clk) begin
		if (qpush.push)
			slot_q[wr_ptr_q] <= qpush.op;
	end

endmodule

/* hw/rtl/tfd_back.sv */
// Back end: drawing and shown stores, fill sweeps, row diff scan, result register.
// Depends on tfd_pkg, tfd_rsp_if.
module tfd_back import tfd_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic      clk,
	input  logic      arst_n,
	input  tfd_head_t qhead,
	output logic      pop,
	output logic      init_done,
	tfd_rsp_if.source rsp
);

	localparam int CW    = tfd_bits(tfd_min(MAX_WIDTH, COL_CAP));
	localparam int RW    = tfd_bits(tfd_min(MAX_HEIGHT, ROW_CAP));
	localparam int AW    = RW + CW;
	localparam int DEPTH = 1 << AW;

	logic [CHAR_W-1:0] draw_mem  [DEPTH];
	logic [CHAR_W-1:0] shown_mem [DEPTH];

	tfd_bstate_e       state_q, state_d;
	tfd_op_t           op_q;
	logic [AW-1:0]     sweep_q;
	logic [WID_W-1:0]  issue_q;
	logic              cmp_v_s1, cmp_v_d;
	logic [CW-1:0]     cmp_col_s1;
	logic [CHAR_W-1:0] draw_rd_s1;
	logic [CHAR_W-1:0] shown_rd_s1;

	logic              draw_we, shown_we, rd_en;
	logic [AW-1:0]     draw_wa, shown_wa, rd_addr;
	logic [CHAR_W-1:0] draw_wd, shown_wd;
	logic              sweep_inc, issue_inc, issue_clr, latch;
	logic              can_emit, differ, stall;

	logic              emit;
	tfd_kind_e         emit_kind;
	logic [ROW_W-1:0]  emit_row;
	logic [COL_W-1:0]  emit_col;
	logic [CHAR_W-1:0] emit_char;
	logic              emit_last;

	logic              res_v_q;
	tfd_kind_e         res_kind_q;
	logic [ROW_W-1:0]  res_row_q;
	logic [COL_W-1:0]  res_col_q;
	logic [CHAR_W-1:0] res_char_q;
	logic              res_last_q;

	assign init_done = (state_q != BS_INIT);
	assign can_emit  = !res_v_q || rsp.ready;
	assign differ    = (draw_rd_s1 != shown_rd_s1);
	assign stall     = cmp_v_s1 && differ && !can_emit;

	// Sequencer: next state and datapath controls
	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		latch     = 1'b0;
		draw_we   = 1'b0;
		draw_wa   = sweep_q;
		draw_wd   = SPACE_CHAR;
		shown_we  = 1'b0;
		shown_wa  = sweep_q;
		shown_wd  = SPACE_CHAR;
		rd_en     = 1'b0;
		rd_addr   = {op_q.row[RW-1:0], issue_q[CW-1:0]};
		sweep_inc = 1'b0;
		issue_inc = 1'b0;
		issue_clr = 1'b0;
		cmp_v_d   = cmp_v_s1;
		emit      = 1'b0;
		emit_kind = KIND_HOME;
		emit_row  = '0;
		emit_col  = '0;
		emit_char = '0;
		emit_last = 1'b0;
		case (state_q)
			BS_INIT: begin
				draw_we   = 1'b1;
				shown_we  = 1'b1;
				sweep_inc = 1'b1;
				if (&sweep_q)
					state_d = BS_IDLE;
			end
			BS_IDLE: begin
				if (qhead.valid) begin
					pop   = 1'b1;
					latch = 1'b1;
					case (qhead.op.code)
						OP_DRAW: begin
							draw_we = 1'b1;
							draw_wa = {qhead.op.row[RW-1:0], qhead.op.col[CW-1:0]};
							draw_wd = qhead.op.ch;
						end
						OP_CLEAR, OP_ERASE: state_d = BS_FILL;
						OP_FLUSH: begin
							issue_clr = 1'b1;
							cmp_v_d   = 1'b0;
							state_d   = BS_SCAN;
						end
						default: ;
					endcase
				end
			end
			BS_FILL: begin
				draw_we   = 1'b1;
				shown_we  = (op_q.code == OP_ERASE);
				sweep_inc = 1'b1;
				if (&sweep_q)
					state_d = (op_q.code == OP_ERASE) ? BS_HOME : BS_IDLE;
			end
			BS_HOME: begin
				if (can_emit) begin
					emit    = 1'b1;
					state_d = BS_CLS;
				end
			end
			BS_CLS: begin
				if (can_emit) begin
					emit      = 1'b1;
					emit_kind = KIND_CLS;
					emit_last = 1'b1;
					state_d   = BS_IDLE;
				end
			end
			BS_SCAN: begin
				// compare stage retires one column while the next is read
				if (!stall) begin
					if (cmp_v_s1 && differ) begin
						emit      = 1'b1;
						emit_kind = KIND_CELL;
						emit_row  = op_q.row;
						emit_col  = COL_W'(cmp_col_s1);
						emit_char = draw_rd_s1;
						shown_we  = 1'b1;
						shown_wa  = {op_q.row[RW-1:0], cmp_col_s1};
						shown_wd  = draw_rd_s1;
					end
					if (issue_q < op_q.ncols) begin
						rd_en     = 1'b1;
						issue_inc = 1'b1;
						cmp_v_d   = 1'b1;
					end else begin
						cmp_v_d = 1'b0;
						state_d = BS_END;
					end
				end
			end
			BS_END: begin
				if (can_emit) begin
					emit      = 1'b1;
					emit_last = 1'b1;
					state_d   = BS_IDLE;
				end
			end
			default: state_d = BS_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= BS_INIT;
			sweep_q  <= '0;
			issue_q  <= '0;
			cmp_v_s1 <= 1'b0;
			res_v_q  <= 1'b0;
		end else begin
			state_q  <= state_d;
			cmp_v_s1 <= cmp_v_d;
			if (sweep_inc)
				sweep_q <= sweep_q + AW'(1);
			if (issue_clr)
				issue_q <= '0;
			else if (issue_inc)
				issue_q <= issue_q + WID_W'(1);
			if (emit)
				res_v_q <= 1'b1;
			else if (rsp.ready)
				res_v_q <= 1'b0;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (latch)
			op_q <= qhead.op;
		if (rd_en)
			cmp_col_s1 <= issue_q[CW-1:0];
		if (emit) begin
			res_kind_q <= emit_kind;
			res_row_q  <= emit_row;
			res_col_q  <= emit_col;
			res_char_q <= emit_char;
			res_last_q <= emit_last;
		end
	end

	// Drawing store
	always_ff @(posedge clk) begin
		if (draw_we)
			draw_mem[draw_wa] <= draw_wd;
		if (rd_en)
			draw_rd_s1 <= draw_mem[rd_addr];
	end

	// Shown store
	always_ff @(posedge clk) begin
		if (shown_we)
			shown_mem[shown_wa] <= shown_wd;
		if (rd_en)
			shown_rd_s1 <= shown_mem[rd_addr];
	end

	assign rsp.valid    = res_v_q;
	assign rsp.kind     = res_kind_q;
	assign rsp.row      = res_row_q;
	assign rsp.col      = res_col_q;
	assign rsp.out_char = res_char_q;
	assign rsp.last     = res_last_q;

endmodule

/* hw/rtl/text_framebuffer_diff_flush.sv */
// Top level of the text framebuffer diff-flush block.
// Depends on tfd_pkg, tfd_ifs, tfd_front, tfd_queue and tfd_back.

// Character framebuffer with a drawing store and a shown store, each one byte
// per cell. Commands enter on req (draw, clear, erase, flush one row) and
// terminal updates leave on rsp. After reset both stores are filled with
// spaces by a pass over 2^(row bits + column bits) entries (512 by default),
// during which req is held not ready; size register writes are taken at any
// time. A draw is written straight into the drawing store. A row flush reads
// its display_width columns one a cycle, unless rsp stalls, through the
// stores' shared read address. Clear and erase sweep the whole store, one
// entry a cycle (512 entries by default), erase then emits its two results.
// A two-entry op queue lets req keep accepting while the back end works.
module text_framebuffer_diff_flush import tfd_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	tfd_req_if.sink              req,
	tfd_rsp_if.source            rsp
);

	tfd_push_t qpush;
	tfd_head_t qhead;
	logic      q_full;
	logic      pop;
	logic      init_done;

	tfd_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.q_full    (q_full),
		.init_done (init_done),
		.qpush     (qpush)
	);

	tfd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.qpush  (qpush),
		.pop    (pop),
		.q_full (q_full),
		.qhead  (qhead)
	);

	tfd_back #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.qhead     (qhead),
		.pop       (pop),
		.init_done (init_done),
		.rsp       (rsp)
	);

	// Queue never overflows
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		qpush.push |-> !q_full)
		else $error("op pushed into a full queue");

	// Back end only pops a present op
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> qhead.valid)
		else $error("pop from an empty queue");

	// Every accepted non-draw command reaches the queue
	a_cmd_queued: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready && req.cmd != CMD_DRAW |-> qpush.push)
		else $error("accepted command not queued");

	// No item is taken before the store init pass ends
	a_no_accept_init: assert property (@(posedge clk) disable iff (!arst_n)
		!init_done |-> !(req.valid && req.ready))
		else $error("item accepted during store init");

endmodule

/* tb/text_framebuffer_diff_flush_test.sv */
// Testbench for text_framebuffer_diff_flush: drives commands, predicts every terminal
// update from a shadow copy of both character stores, and checks each result in order.
// Depends on tfd_pkg, tfd_ifs and the RTL of the block.
module text_framebuffer_diff_flush_test;
	import tfd_pkg::*;

	localparam int COL_LIM      = (DEF_MAX_WIDTH < COL_CAP) ? DEF_MAX_WIDTH : COL_CAP;
	localparam int ROW_LIM      = (DEF_MAX_HEIGHT < ROW_CAP) ? DEF_MAX_HEIGHT : ROW_CAP;
	localparam int STRIDE       = DEF_MAX_WIDTH;
	localparam int CELLS        = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
	localparam int DRAIN_CYCLES = 600;
	localparam int HOLD_CYCLES  = 300;
	localparam int WATCHDOG     = 5000;
	localparam int GAP_PCT      = 18;

	typedef struct packed {
		tfd_kind_e         kind;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
		logic [CHAR_W-1:0] chr;
		logic              last;
	} term_update_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wen;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;

	tfd_req_if req();
	tfd_rsp_if rsp();

	text_framebuffer_diff_flush dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.rsp       (rsp)
	);

	// Shadow stores and size registers
	logic [CHAR_W-1:0] draw_copy  [CELLS];
	logic [CHAR_W-1:0] shown_copy [CELLS];
	logic [WID_W-1:0]  width_reg;
	logic [HGT_W-1:0]  height_reg;
	term_update_t      pending_updates[$];
	term_update_t      want;

	int   gap_pct   = GAP_PCT;
	int   stall_pct = GAP_PCT;
	int   hold_req  = 0;
	int   hold_ack  = 0;
	int   hold_left  = 0;
	int   idle_cycles = 0;
	int   n_items   = 0;
	int   n_updates = 0;
	int   n_fail    = 0;

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic int cols_in_use();
		if (width_reg == 0) return 1;
		if (width_reg > COL_LIM) return COL_LIM;
		return width_reg;
	endfunction

	function automatic int rows_in_use();
		if (height_reg == 0) return 1;
		if (height_reg > ROW_LIM) return ROW_LIM;
		return height_reg;
	endfunction

	function automatic void push_update(input tfd_kind_e kind, input logic [ROW_W-1:0] row,
			input logic [COL_W-1:0] col, input logic [CHAR_W-1:0] chr, input logic last);
		term_update_t u;
		u.kind = kind;
		u.row  = row;
		u.col  = col;
		u.chr  = chr;
		u.last = last;
		pending_updates.push_back(u);
	endfunction

	// Apply one accepted command to the shadow stores and queue the updates it causes
	function automatic void frame_predict(input tfd_cmd_e cmd, input logic [X_W-1:0] x,
			input logic [Y_W-1:0] y, input logic [CHAR_W-1:0] ch);
		int w;
		int h;
		int a;
		w = cols_in_use();
		h = rows_in_use();
		case (cmd)
			CMD_DRAW: begin
				// draws outside the size in use are dropped
				if (x < w && y < h) draw_copy[(h - 1 - y) * STRIDE + x] = ch;
			end
			CMD_CLEAR: begin
				for (a = 0; a < CELLS; a++) draw_copy[a] = SPACE_CHAR;
			end
			CMD_ERASE: begin
				for (a = 0; a < CELLS; a++) begin
					draw_copy[a]  = SPACE_CHAR;
					shown_copy[a] = SPACE_CHAR;
				end
				push_update(KIND_HOME, '0, '0, '0, 1'b0);
				push_update(KIND_CLS, '0, '0, '0, 1'b1);
			end
			CMD_FLUSH: begin
				// rows outside the size only give the cursor home
				if (y < h) begin
					for (int c = 0; c < w; c++) begin
						a = y * STRIDE + c;
						if (draw_copy[a] != shown_copy[a]) begin
							push_update(KIND_CELL, y, COL_W'(c), draw_copy[a], 1'b0);
							shown_copy[a] = draw_copy[a];
						end
					end
				end
				push_update(KIND_HOME, '0, '0, '0, 1'b1);
			end
			default: ;
		endcase
	endfunction

	// Result checker: compare each accepted update with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin
			n_updates++;
			if (pending_updates.size() == 0) begin
				$error("unexpected update: kind %0d row %0d col %0d char %0h last %0d",
					rsp.kind, rsp.row, rsp.col, rsp.out_char, rsp.last);
				n_fail++;
			end else begin
				want = pending_updates.pop_front();
				if (rsp.kind !== want.kind) begin
					$error("kind: expected %0d, got %0d", want.kind, rsp.kind);
					n_fail++;
				end
				if (rsp.row !== want.row) begin
					$error("row: expected %0d, got %0d", want.row, rsp.row);
					n_fail++;
				end
				if (rsp.col !== want.col) begin
					$error("col: expected %0d, got %0d", want.col, rsp.col);
					n_fail++;
				end
				if (rsp.out_char !== want.chr) begin
					$error("out_char: expected %0h, got %0h", want.chr, rsp.out_char);
					n_fail++;
				end
				if (rsp.last !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, rsp.last);
					n_fail++;
				end
			end
		end
	end

	// Receiver: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_ack != hold_req) begin
			hold_ack  = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Watchdog on cycles with no item moving on either channel
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG) begin
			$display("watchdog: no item moved for %0d cycles, %0d updates outstanding",
				WATCHDOG, pending_updates.size());
			$display("text_framebuffer_diff_flush_test: FAIL");
			$finish;
		end
	end

	// Offer one command, with random gaps, and predict it once accepted
	task automatic send_cmd(input tfd_cmd_e cmd, input logic [X_W-1:0] x,
			input logic [Y_W-1:0] y, input logic [CHAR_W-1:0] ch);
		while ($urandom_range(99) < gap_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.cmd   <= cmd;
		req.x     <= x;
		req.y     <= y;
		req.ch    <= ch;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		frame_predict(cmd, x, y, ch);
		n_items++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_wen <= 1'b0;
		if (idx == REG_WIDTH)
			width_reg = val[WID_W-1:0];
		else
			height_reg = val[HGT_W-1:0];
	endtask

	// End with a flush so every earlier command is done, then let the block go quiet
	task automatic settle();
		send_cmd(CMD_FLUSH, X_W'($urandom), Y_W'($urandom), CHAR_W'($urandom));
		req.valid <= 1'b0;
		while (pending_updates.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic random_cmd();
		int w;
		int h;
		int r;
		w = cols_in_use();
		h = rows_in_use();
		r = $urandom_range(99);
		if (r < 58) begin
			if ($urandom_range(9) < 9)
				send_cmd(CMD_DRAW, X_W'($urandom_range(w - 1)), Y_W'($urandom_range(h - 1)),
					($urandom_range(9) < 2) ? SPACE_CHAR : CHAR_W'($urandom));
			else
				send_cmd(CMD_DRAW, X_W'($urandom), Y_W'($urandom), CHAR_W'($urandom));
		end else if (r < 86) begin
			if ($urandom_range(9) < 8)
				send_cmd(CMD_FLUSH, X_W'($urandom), Y_W'($urandom_range(h - 1)),
					CHAR_W'($urandom));
			else
				send_cmd(CMD_FLUSH, X_W'($urandom), Y_W'($urandom), CHAR_W'($urandom));
		end else if (r < 93) begin
			send_cmd(CMD_CLEAR, X_W'($urandom), Y_W'($urandom), CHAR_W'($urandom));
		end else begin
			send_cmd(CMD_ERASE, X_W'($urandom), Y_W'($urandom), CHAR_W'($urandom));
		end
	endtask

	// Corners of the full screen, extreme characters, a flush with nothing to update
	task automatic test_corners();
		send_cmd(CMD_DRAW, 5'd0, 4'd0, 8'h00);
		send_cmd(CMD_DRAW, 5'd31, 4'd15, 8'hFF);
		send_cmd(CMD_DRAW, 5'd31, 4'd0, 8'h80);
		send_cmd(CMD_DRAW, 5'd0, 4'd15, 8'h7F);
		send_cmd(CMD_DRAW, 5'd5, 4'd15, SPACE_CHAR);
		send_cmd(CMD_FLUSH, 5'd0, 4'd0, 8'd0);
		send_cmd(CMD_FLUSH, 5'd31, 4'd15, 8'hFF);
		send_cmd(CMD_FLUSH, 5'd0, 4'd15, 8'd0);
	endtask

	// Clear of the drawing store only, and erase of both
	task automatic test_clear_erase();
		send_cmd(CMD_DRAW, 5'd3, 4'd12, 8'h55);
		send_cmd(CMD_CLEAR, 5'd0, 4'd0, 8'd0);
		send_cmd(CMD_FLUSH, 5'd0, 4'd3, 8'd0);
		send_cmd(CMD_DRAW, 5'd7, 4'd14, 8'hAA);
		send_cmd(CMD_FLUSH, 5'd0, 4'd1, 8'd0);
		send_cmd(CMD_CLEAR, 5'd31, 4'd15, 8'hFF);
		send_cmd(CMD_FLUSH, 5'd0, 4'd1, 8'd0);
		send_cmd(CMD_DRAW, 5'd9, 4'd9, 8'h33);
		send_cmd(CMD_ERASE, 5'd0, 4'd0, 8'd0);
	endtask

	// Size registers at zero and above their limits; draws and flushes off the screen
	task automatic test_size_limits();
		settle();
		write_reg(REG_WIDTH, 6'd0);
		write_reg(REG_HEIGHT, 6'h20);
		send_cmd(CMD_DRAW, 5'd1, 4'd0, 8'h41);
		send_cmd(CMD_DRAW, 5'd0, 4'd1, 8'h42);
		send_cmd(CMD_DRAW, 5'd0, 4'd0, 8'h99);
		send_cmd(CMD_FLUSH, 5'd0, 4'd1, 8'd0);
		send_cmd(CMD_FLUSH, 5'd0, 4'd0, 8'd0);
		settle();
		write_reg(REG_WIDTH, 6'd63);
		write_reg(REG_HEIGHT, 6'h3F);
		send_cmd(CMD_DRAW, 5'd31, 4'd15, 8'h5A);
		send_cmd(CMD_FLUSH, 5'd0, 4'd0, 8'd0);
		send_cmd(CMD_FLUSH, 5'd0, 4'd15, 8'd0);
	endtask

	// Receiver holds off while flushes with many updates keep coming
	task automatic test_backpressure();
		int r;
		gap_pct = 0;
		hold_req++;
		repeat (10) begin
			r = $urandom_range(rows_in_use() - 1);
			repeat (6) send_cmd(CMD_DRAW, X_W'($urandom_range(cols_in_use() - 1)),
				Y_W'(rows_in_use() - 1 - r), CHAR_W'($urandom));
			send_cmd(CMD_FLUSH, X_W'($urandom), Y_W'(r), CHAR_W'($urandom));
		end
		gap_pct = GAP_PCT;
	endtask

	// Random commands over several screen sizes, the size kept across changes
	task automatic test_random_phases();
		logic [CFG_W-1:0] wv;
		logic [CFG_W-1:0] hv;
		for (int k = 0; k < 6; k++) begin
			case (k)
				0: begin wv = 6'd32; hv = 6'd16; end
				1: begin wv = 6'd1;  hv = 6'd16; end
				2: begin wv = 6'd32; hv = 6'd1;  end
				4: begin wv = CFG_W'($urandom); hv = CFG_W'($urandom); end
				default: begin
					wv = CFG_W'($urandom_range(1, 32));
					hv = CFG_W'($urandom_range(1, 16));
				end
			endcase
			settle();
			write_reg(REG_WIDTH, wv);
			write_reg(REG_HEIGHT, hv);
			// one phase runs with no idling on either side
			gap_pct   = (k == 3) ? 0 : GAP_PCT;
			stall_pct = (k == 3) ? 0 : GAP_PCT;
			repeat (33) random_cmd();
		end
		gap_pct   = GAP_PCT;
		stall_pct = GAP_PCT;
	endtask

	initial begin
		req.valid <= 1'b0;
		req.cmd   <= CMD_DRAW;
		req.x     <= '0;
		req.y     <= '0;
		req.ch    <= '0;
		cfg_wen   <= 1'b0;
		cfg_index <= REG_WIDTH;
		cfg_wdata <= '0;
		arst_n    <= 1'b0;
		for (int a = 0; a < CELLS; a++) begin
			draw_copy[a]  = SPACE_CHAR;
			shown_copy[a] = SPACE_CHAR;
		end
		width_reg  = WIDTH_RST;
		height_reg = HEIGHT_RST;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		test_corners();
		test_clear_erase();
		test_size_limits();
		test_backpressure();
		test_random_phases();
		settle();

		$display("covered %0d commands and %0d terminal updates over screen sizes 1x1 to 32x16,",
			n_items, n_updates);
		$display("including off-screen draws and flushes, clears, erases and a long output stall");
		if (n_fail == 0 && pending_updates.size() == 0)
			$display("text_framebuffer_diff_flush_test: PASS");
		else
			$display("text_framebuffer_diff_flush_test: FAIL");
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/tfd_pkg.sv
hw/rtl/tfd_ifs.sv
hw/rtl/tfd_front.sv
hw/rtl/tfd_queue.sv
hw/rtl/tfd_back.sv
hw/rtl/text_framebuffer_diff_flush.sv
tb/text_framebuffer_diff_flush_test.sv
